@@ hdl/gsa_pkg.sv @@
// shared types and constants for the guarded slot allocator
package gsa_pkg;

   localparam int unsigned CMD_ALLOC = 0;
   localparam int unsigned CMD_FREE  = 1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_REJECT   = 3'd1,
      ST_NO_SLOT  = 3'd2,
      ST_BAD_FREE = 3'd3,
      ST_DBL_FREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_ENABLED    = 3'd0,
      CSR_POOL_BASE  = 3'd1,
      CSR_PAGE_SHIFT = 3'd2,
      CSR_SLOTS      = 3'd3,
      CSR_RNG_SEED   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DRAW,
      S_DIV,
      S_LIST_RD,
      S_LIST_WAIT,
      S_PLACE,
      S_ADDR,
      S_FREE_RD,
      S_FREE_WAIT,
      S_FREE_CHK,
      S_DONE
   } state_type;

   localparam int unsigned MIN_SHIFT  = 12;
   localparam int unsigned MAX_SHIFT  = 16;
   localparam int unsigned DEF_ALIGN  = 16;
   localparam int unsigned RNG_SH_A   = 13;
   localparam int unsigned RNG_SH_B   = 17;
   localparam int unsigned RNG_SH_C   = 5;

   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << RNG_SH_A);
      y = y ^ (y >> RNG_SH_B);
      y = y ^ (y << RNG_SH_C);
      return y;
   endfunction

endpackage

@@ hdl/guarded_slot_allocator.sv @@
// guarded slot allocator top level
// One request beat yields exactly one response beat. A rejected allocate or
// one with no free slot answers straight from the check step, an allocate
// from the fresh range passes the place and address steps, a free reads and
// checks the slot metadata, and an allocate that picks from the free list
// first runs a 32-step serial remainder unit (one quotient bit per cycle)
// and then reads the free list. The next request beat is taken only after
// the response has been taken. Slot metadata (owner address, freed flag)
// and the free list sit in synchronous memories with registered read data;
// after reset a clearing pass zeroes the metadata memory before the first
// request beat is taken. Only one request is in flight at a time; the
// response register holds its beat until taken.
module guarded_slot_allocator
   import gsa_pkg::*;
#(
   parameter int unsigned SLOTS     = 16,
   parameter int unsigned ADDR_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_index,
   input  logic [ADDR_BITS-1:0] csr_wdata,
   input  logic                 s_axis_req_tvalid,
   output logic                 s_axis_req_tready,
   // req_size[16:0], req_align[33:17], free_addr[ADDR_BITS+33:34], zero pad
   input  logic [((ADDR_BITS+34+7)/8)*8-1:0] s_axis_req_tdata,
   // cmd
   input  logic                 s_axis_req_tuser,
   output logic                 m_axis_rsp_tvalid,
   input  logic                 m_axis_rsp_tready,
   // status[2:0], user_addr[ADDR_BITS+2:3], slot_index[.. +SLOT_W], zero pad
   output logic [((3+ADDR_BITS+((SLOTS>1)?$clog2(SLOTS):1)+7)/8)*8-1:0]
                                m_axis_rsp_tdata
);

   localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW    = $clog2(SLOTS + 1);
   localparam int unsigned IN_W  = ((ADDR_BITS + 34 + 7) / 8) * 8;
   localparam int unsigned OUT_W = ((3 + ADDR_BITS + SW + 7) / 8) * 8;

   // configuration
   logic                 enabled_ff;
   logic [ADDR_BITS-1:0] base_ff;
   logic [4:0]           shift_ff;
   logic [4:0]           slots_cfg_ff;
   logic [31:0]          rng_ff, rng_in;

   // pool state
   logic [CW-1:0] fresh_ff, fresh_in;
   logic [CW-1:0] flen_ff, flen_in;

   // memories
   logic [ADDR_BITS:0]   meta_mem [SLOTS];
   logic [SW-1:0]        list_mem [SLOTS];
   logic                 meta_we;
   logic [SW-1:0]        meta_waddr, meta_raddr;
   logic [ADDR_BITS:0]   meta_wdata, meta_rdata_ff;
   logic                 list_we;
   logic [SW-1:0]        list_waddr, list_raddr;
   logic [SW-1:0]        list_wdata, list_rdata_ff;

   // clearing pass
   logic          clr_busy_ff, clr_busy_in;
   logic [SW-1:0] clr_idx_ff, clr_idx_in;

   // request registers
   logic                 cmd_ff;
   logic [16:0]          size_ff, align_ff;
   logic [ADDR_BITS-1:0] faddr_ff;

   // working registers
   state_type            state_ff, state_in;
   logic [SW-1:0]        slot_ff, slot_in;
   logic [SW-1:0]        pick_ff, pick_in;
   logic [31:0]          dividend_ff, dividend_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [5:0]           div_cnt_ff, div_cnt_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SW-1:0]        rsp_slot_ff, rsp_slot_in;

   // effective config
   logic [4:0]           eff_sh;
   logic [CW-1:0]        eff_n;
   logic [ADDR_BITS-1:0] page;
   logic [16:0]          page17;

   always_comb begin
      if (shift_ff < 5'(MIN_SHIFT)) eff_sh = 5'(MIN_SHIFT);
      else if (shift_ff > 5'(MAX_SHIFT)) eff_sh = 5'(MAX_SHIFT);
      else eff_sh = shift_ff;
      if (slots_cfg_ff == 5'd0) eff_n = CW'(1);
      else if (32'(slots_cfg_ff) > 32'(SLOTS)) eff_n = CW'(SLOTS);
      else eff_n = CW'(slots_cfg_ff);
      page   = ADDR_BITS'(1) << eff_sh;
      page17 = 17'(1) << eff_sh;
   end

   // normalized request
   logic [16:0] nsize, nalign, amask;
   logic        bad_req;
   always_comb begin
      nsize   = (size_ff == 17'd0) ? 17'd1 : size_ff;
      nalign  = (align_ff == 17'd0) ? 17'(DEF_ALIGN) : align_ff;
      amask   = nalign - 17'd1;
      bad_req = !enabled_ff || ((nalign & amask) != 17'd0) || (nalign > page17)
                || (nsize > page17);
   end

   // nearest slot for a free, computed combinationally from the registered free address
   logic [ADDR_BITS-1:0] off_a, lo_bound, hi_bound, a_adj, off_adj;
   logic [ADDR_BITS:0]   n_pages;
   logic [ADDR_BITS-1:0] slot_raw;
   logic [SW-1:0]        near_slot;
   always_comb begin
      n_pages  = (ADDR_BITS+1)'(2) * (ADDR_BITS+1)'(eff_n) + (ADDR_BITS+1)'(1);
      lo_bound = base_ff + page;
      hi_bound = base_ff + ADDR_BITS'(n_pages[ADDR_BITS-1:0] << eff_sh) - page;
      off_a    = faddr_ff - base_ff;
      if (off_a[eff_sh]) a_adj = faddr_ff;
      else if ((faddr_ff & (page - ADDR_BITS'(1))) <= (page >> 1))
         a_adj = faddr_ff - page;
      else a_adj = faddr_ff + page;
      off_adj  = a_adj - base_ff;
      slot_raw = off_adj >> (eff_sh + 5'd1);
      if (faddr_ff <= lo_bound) near_slot = '0;
      else if (faddr_ff > hi_bound) near_slot = SW'(eff_n - CW'(1));
      else if (slot_raw >= ADDR_BITS'(eff_n)) near_slot = SW'(eff_n - CW'(1));
      else near_slot = slot_raw[SW-1:0];
   end

   // slot start address
   logic [ADDR_BITS-1:0] slot_start;
   logic [ADDR_BITS-1:0] pend, up_addr, dn_addr;
   logic [ADDR_BITS-1:0] amask_w;
   always_comb begin
      slot_start = base_ff + ((ADDR_BITS'(2) * ADDR_BITS'(slot_ff) + ADDR_BITS'(1))
                              << eff_sh);
      amask_w = ADDR_BITS'(amask);
      pend    = start_ff + page;
      up_addr = start_ff + ((ADDR_BITS'(nalign) - (start_ff & amask_w)) & amask_w);
      dn_addr = (pend - ADDR_BITS'(nsize)) & ~amask_w;
   end

   // serial remainder step
   logic [CW:0] rem_sh;
   always_comb rem_sh = {rem_ff, dividend_ff[31]};

   assign s_axis_req_tready = (state_ff == S_IDLE) && !clr_busy_ff && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (s_axis_req_tvalid && s_axis_req_tready) state_in = S_CHECK;
         S_CHECK:     begin
            if (cmd_ff == 1'(CMD_FREE)) state_in = S_FREE_RD;
            else if (bad_req || (fresh_ff >= eff_n && flen_ff == '0)) state_in = S_DONE;
            else if (fresh_ff < eff_n) state_in = S_PLACE;
            else state_in = S_DRAW;
         end
         S_DRAW:      state_in = S_DIV;
         S_DIV:       if (div_cnt_ff == 6'd31) state_in = S_LIST_RD;
         S_LIST_RD:   state_in = S_LIST_WAIT;
         S_LIST_WAIT: state_in = S_PLACE;
         S_PLACE:     state_in = S_ADDR;
         S_ADDR:      state_in = S_DONE;
         S_FREE_RD:   state_in = S_FREE_WAIT;
         S_FREE_WAIT: state_in = S_FREE_CHK;
         S_FREE_CHK:  state_in = S_DONE;
         S_DONE:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rng_in        = rng_ff;
      fresh_in      = fresh_ff;
      flen_in       = flen_ff;
      slot_in       = slot_ff;
      pick_in       = pick_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      start_in      = start_ff;
      rsp_valid_in  = rsp_valid_ff && !m_axis_rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_slot_in   = rsp_slot_ff;
      meta_we       = 1'b0;
      meta_waddr    = slot_ff;
      meta_wdata    = '0;
      meta_raddr    = near_slot;
      list_we       = 1'b0;
      list_waddr    = flen_ff[SW-1:0];
      list_wdata    = slot_ff;
      list_raddr    = pick_ff;
      clr_busy_in   = clr_busy_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_busy_ff) begin
         meta_we    = 1'b1;
         meta_waddr = clr_idx_ff;
         clr_idx_in = clr_idx_ff + SW'(1);
         if (32'(clr_idx_ff) == SLOTS - 1) clr_busy_in = 1'b0;
      end
      unique case (state_ff)
         S_CHECK: begin
            rsp_status_in = ST_OK;
            rsp_addr_in   = '0;
            rsp_slot_in   = '0;
            if (cmd_ff == 1'(CMD_FREE)) begin
               slot_in = near_slot;
            end else if (bad_req) begin
               rsp_status_in = ST_REJECT;
            end else if (fresh_ff >= eff_n && flen_ff == '0) begin
               rsp_status_in = ST_NO_SLOT;
            end else if (fresh_ff < eff_n) begin
               slot_in  = fresh_ff[SW-1:0];
               fresh_in = fresh_ff + CW'(1);
            end
         end
         S_DRAW: begin
            rng_in      = xorshift(rng_ff);
            dividend_in = xorshift(rng_ff);
            rem_in      = '0;
            div_cnt_in  = '0;
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (rem_sh >= {1'b0, flen_ff}) rem_in = CW'(rem_sh - {1'b0, flen_ff});
            else rem_in = rem_sh[CW-1:0];
            dividend_in = dividend_ff << 1;
            div_cnt_in  = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd31) begin
               if (rem_sh >= {1'b0, flen_ff}) pick_in = SW'(rem_sh - {1'b0, flen_ff});
               else pick_in = rem_sh[SW-1:0];
            end
         end
         S_LIST_RD: begin
            list_raddr = pick_ff;
         end
         S_LIST_WAIT: begin
            // move tail entry into the hole after reading the picked one
            slot_in    = list_rdata_ff;
            list_raddr = SW'(flen_ff - CW'(1));
            flen_in    = flen_ff - CW'(1);
         end
         S_PLACE: begin
            start_in = slot_start;
            rng_in   = xorshift(rng_ff);
         end
         S_ADDR: begin
            rsp_status_in = ST_OK;
            rsp_slot_in   = slot_ff;
            rsp_addr_in   = rng_ff[0] ? dn_addr : up_addr;
            meta_we       = 1'b1;
            meta_waddr    = slot_ff;
            meta_wdata    = {1'b0, rng_ff[0] ? dn_addr : up_addr};
         end
         S_FREE_RD:   meta_raddr = slot_ff;
         S_FREE_WAIT: meta_raddr = slot_ff;
         S_FREE_CHK: begin
            rsp_slot_in = slot_ff;
            if (meta_rdata_ff[ADDR_BITS-1:0] != faddr_ff) begin
               rsp_status_in = ST_BAD_FREE;
               rsp_addr_in   = faddr_ff;
            end else if (meta_rdata_ff[ADDR_BITS]) begin
               rsp_status_in = ST_DBL_FREE;
               rsp_addr_in   = faddr_ff;
            end else begin
               meta_we    = 1'b1;
               meta_waddr = slot_ff;
               meta_wdata = {1'b1, faddr_ff};
               if (flen_ff < eff_n) begin
                  list_we    = 1'b1;
                  list_waddr = flen_ff[SW-1:0];
                  list_wdata = slot_ff;
                  flen_in    = flen_ff + CW'(1);
               end
            end
         end
         S_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
      // a seed write reloads the generator
      if (csr_wr_en && csr_index == CSR_RNG_SEED) rng_in = csr_wdata[31:0];
   end

   // free-list removal: pick <- tail, done when the tail read lands
   logic          tail_move_ff;
   logic [SW-1:0] tail_pick_ff;

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
      meta_rdata_ff <= meta_mem[meta_raddr];
      if (list_we) list_mem[list_waddr] <= list_wdata;
      else if (tail_move_ff) list_mem[tail_pick_ff] <= list_rdata_ff;
      list_rdata_ff <= list_mem[list_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         base_ff      <= '0;
         shift_ff     <= 5'(MIN_SHIFT);
         slots_cfg_ff <= 5'd16;
         rng_ff       <= 32'd1;
         fresh_ff     <= '0;
         flen_ff      <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         tail_move_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         fresh_ff     <= fresh_in;
         flen_ff      <= flen_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         tail_move_ff <= (state_ff == S_LIST_WAIT);
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ENABLED:    enabled_ff   <= csr_wdata[0];
               CSR_POOL_BASE:  base_ff      <= csr_wdata;
               CSR_PAGE_SHIFT: shift_ff     <= csr_wdata[4:0];
               CSR_SLOTS:      slots_cfg_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tail_pick_ff  <= pick_ff;
      slot_ff       <= slot_in;
      pick_ff       <= pick_in;
      dividend_ff   <= dividend_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      start_ff      <= start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (s_axis_req_tvalid && s_axis_req_tready) begin
         cmd_ff   <= s_axis_req_tuser;
         size_ff  <= s_axis_req_tdata[16:0];
         align_ff <= s_axis_req_tdata[33:17];
         faddr_ff <= s_axis_req_tdata[ADDR_BITS+33:34];
      end
   end

   assign m_axis_rsp_tvalid = rsp_valid_ff;
   assign m_axis_rsp_tdata  = OUT_W'({rsp_slot_ff, rsp_addr_ff, rsp_status_ff});

   logic unused_in;
   assign unused_in = ^{s_axis_req_tdata[IN_W-1:ADDR_BITS+34], 1'b0};

endmodule

@@ hdl/gsa_checker.sv @@
// port-level checks for the guarded slot allocator
module gsa_checker
   import gsa_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       s_axis_req_tvalid,
   input logic       s_axis_req_tready,
   input logic       m_axis_rsp_tvalid,
   input logic       m_axis_rsp_tready,
   input logic [2:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      m_axis_rsp_tvalid && !m_axis_rsp_tready |=> m_axis_rsp_tvalid)
      else $error("response beat dropped");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      m_axis_rsp_tvalid |-> !s_axis_req_tready)
      else $error("request taken while response pending");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      s_axis_req_tvalid && s_axis_req_tready |=> !m_axis_rsp_tvalid)
      else $error("response too early");

   a_status: assert property (@(posedge clock) disable iff (reset)
      m_axis_rsp_tvalid |-> rsp_status <= 3'd4)
      else $error("bad status code");

endmodule

bind guarded_slot_allocator gsa_checker u_gsa_checker (
   .clock             (clock),
   .reset             (reset),
   .s_axis_req_tvalid (s_axis_req_tvalid),
   .s_axis_req_tready (s_axis_req_tready),
   .m_axis_rsp_tvalid (m_axis_rsp_tvalid),
   .m_axis_rsp_tready (m_axis_rsp_tready),
   .rsp_status        (m_axis_rsp_tdata[2:0])
);

@@ tb/sv/guarded_slot_allocator_chk.sv @@
// checker for the guarded slot allocator: models the pool and compares every response beat
module guarded_slot_allocator_chk
   import gsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [87:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          errors,
   output int          pending
);
   localparam logic [63:0] AMASK = 64'h0000_FFFF_FFFF_FFFF;

   // first member lands in the highest bits
   typedef struct packed {
      logic [3:0]  slot_index;
      logic [47:0] user_addr;
      logic [2:0]  status;
   } rsp_beat_t;

   logic        pool_on;
   logic [47:0] pool_base;
   logic [4:0]  page_shift;
   logic [4:0]  slot_cfg;
   logic [31:0] rng_seed;

   int unsigned fresh_cnt;
   int unsigned list_len;
   logic [3:0]  free_slots [16];
   logic [47:0] owner [16];
   logic        freed [16];
   logic [31:0] rng;

   rsp_beat_t grant_q [$];

   function automatic int unsigned shift_eff();
      if (page_shift < MIN_SHIFT) return MIN_SHIFT;
      if (page_shift > MAX_SHIFT) return MAX_SHIFT;
      return page_shift;
   endfunction

   function automatic int unsigned slots_eff();
      if (slot_cfg < 1) return 1;
      if (slot_cfg > 16) return 16;
      return slot_cfg;
   endfunction

   function automatic logic [31:0] rng_next();
      logic [31:0] x;
      x = rng;
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      rng = x;
      return x;
   endfunction

   function automatic int unsigned offset_slot(logic [63:0] a, int unsigned sh, int unsigned n);
      logic [63:0] s;
      s = ((a - {16'd0, pool_base}) & AMASK) >> (sh + 1);
      return (s >= n) ? n - 1 : int'(s);
   endfunction

   function automatic int unsigned near_slot(logic [63:0] a, int unsigned sh, int unsigned n);
      logic [63:0] pg;
      logic [63:0] base;
      logic [63:0] last;
      pg = 64'd1 << sh;
      base = {16'd0, pool_base};
      last = (base + pg * (1 + 2 * n)) & AMASK;
      if (a <= ((base + pg) & AMASK)) return 0;
      if (a > ((last - pg) & AMASK)) return n - 1;
      // inside a data page, or a guard page rounded to the closer neighbor
      if (((((a - base) & AMASK) >> sh) & 64'd1) != 0) return offset_slot(a, sh, n);
      if ((a & (pg - 1)) <= (pg >> 1)) return offset_slot((a - pg) & AMASK, sh, n);
      return offset_slot((a + pg) & AMASK, sh, n);
   endfunction

   function automatic rsp_beat_t pool_step(logic is_free, logic [16:0] sz_in,
                                           logic [16:0] al_in, logic [47:0] fa);
      rsp_beat_t r;
      logic [63:0] sz, al, pg, start, pend, ua;
      int unsigned sh, n, slot, pick;
      r = '0;
      sh = shift_eff();
      n = slots_eff();
      pg = 64'd1 << sh;
      sz = {47'd0, sz_in};
      al = {47'd0, al_in};
      if (!is_free) begin
         if (sz == 0) sz = 1;
         if (al == 0) al = DEF_ALIGN;
         if (!pool_on || (al & (al - 1)) != 0 || al > pg || sz > pg) begin
            r.status = ST_REJECT;
         end else if (fresh_cnt >= n && list_len == 0) begin
            r.status = ST_NO_SLOT;
         end else begin
            if (fresh_cnt < n) begin
               slot = fresh_cnt;
               fresh_cnt++;
            end else begin
               pick = rng_next() % list_len;
               slot = free_slots[pick];
               list_len--;
               free_slots[pick] = free_slots[list_len];
            end
            start = ({16'd0, pool_base} + pg * (1 + 2 * slot)) & AMASK;
            pend = (start + pg) & AMASK;
            if ((rng_next() & 1) == 0)
               ua = (start + ((al - (start & (al - 1))) & (al - 1))) & AMASK;
            else
               ua = ((pend - sz) & AMASK) & ~(al - 1);
            owner[slot] = ua[47:0];
            freed[slot] = 1'b0;
            r.status = ST_OK;
            r.user_addr = ua[47:0];
            r.slot_index = slot[3:0];
         end
      end else begin
         slot = near_slot({16'd0, fa}, sh, n);
         r.slot_index = slot[3:0];
         if (owner[slot] != fa) begin
            r.status = ST_BAD_FREE;
            r.user_addr = fa;
         end else if (freed[slot]) begin
            r.status = ST_DBL_FREE;
            r.user_addr = fa;
         end else begin
            freed[slot] = 1'b1;
            // a full list drops the push but the slot is still marked freed
            if (list_len < n && list_len < 16) begin
               free_slots[list_len] = slot[3:0];
               list_len++;
            end
         end
      end
      return r;
   endfunction

   assign pending = grant_q.size();

   always @(posedge clock) begin
      rsp_beat_t got, want;
      if (reset) begin
         errors = 0;
         pool_on = 1'b0;
         pool_base = '0;
         page_shift = 5'(MIN_SHIFT);
         slot_cfg = 5'd16;
         rng_seed = 32'd1;
         rng = 32'd1;
         fresh_cnt = 0;
         list_len = 0;
         for (int i = 0; i < 16; i++) begin
            free_slots[i] = '0;
            owner[i] = '0;
            freed[i] = 1'b0;
         end
         grant_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLED:    pool_on = csr_wdata[0];
               CSR_POOL_BASE:  pool_base = csr_wdata;
               CSR_PAGE_SHIFT: page_shift = csr_wdata[4:0];
               CSR_SLOTS:      slot_cfg = csr_wdata[4:0];
               CSR_RNG_SEED: begin
                  rng_seed = csr_wdata[31:0];
                  rng = rng_seed;
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[54:0];
            if (grant_q.size() == 0) begin
               $display("%0t: unexpected response beat %h", $time, got);
               errors++;
            end else begin
               want = grant_q.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, got.status);
                  errors++;
               end
               if (got.user_addr != want.user_addr) begin
                  $display("%0t: user_addr expected %h actual %h", $time,
                           want.user_addr, got.user_addr);
                  errors++;
               end
               if (got.slot_index != want.slot_index) begin
                  $display("%0t: slot_index expected %0d actual %0d", $time,
                           want.slot_index, got.slot_index);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            grant_q.push_back(pool_step(req_tuser == CMD_FREE, req_tdata[16:0],
                                        req_tdata[33:17], req_tdata[81:34]));
      end
   end
endmodule

@@ tb/sv/guarded_slot_allocator_tb.sv @@
// testbench top for the guarded slot allocator: stimulus, config phases and verdict
module guarded_slot_allocator_tb;
   import gsa_pkg::*;

   localparam int LIMIT = 1000000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   int          errors;
   int          pending;
   int          cycles;
   bit          no_idle;

   int unsigned cur_shift;
   logic [47:0] cur_base;
   int unsigned cur_slots;
   logic [47:0] live_addr [$];
   logic [47:0] gone_addr [$];
   logic        sent_cmd [$];

   guarded_slot_allocator u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .s_axis_req_tvalid(req_tvalid), .s_axis_req_tready(req_tready),
      .s_axis_req_tdata(req_tdata), .s_axis_req_tuser(req_tuser),
      .m_axis_rsp_tvalid(rsp_tvalid), .m_axis_rsp_tready(rsp_tready),
      .m_axis_rsp_tdata(rsp_tdata)
   );

   guarded_slot_allocator_chk u_chk (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // remember granted addresses so frees can hand them back
   always @(posedge clock) begin
      logic c;
      if (!reset) begin
         if (req_tvalid && req_tready) sent_cmd.push_back(req_tuser);
         if (rsp_tvalid && rsp_tready && sent_cmd.size() > 0) begin
            c = sent_cmd.pop_front();
            if (c == CMD_ALLOC && rsp_tdata[2:0] == ST_OK) live_addr.push_back(rsp_tdata[50:3]);
         end
      end
   end

   // response side back-pressure
   initial begin
      int stall;
      int r;
      stall = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else begin
            r = $urandom_range(0, 99);
            if (!no_idle && r < 3) stall = $urandom_range(20, 60);
            else if (!no_idle && r < 25) stall = $urandom_range(0, 2);
            rsp_tready <= (stall == 0);
         end
      end
   end

   task automatic csr_write(csr_index_type idx, logic [47:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
   endtask

   task automatic send(logic cmd, logic [16:0] sz, logic [16:0] al, logic [47:0] fa);
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {6'd0, fa, al, sz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic req_gap();
      if (!no_idle && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 0;
         if ($urandom_range(0, 99) < 5) repeat ($urandom_range(20, 60)) @(negedge clock);
         else repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic configure(logic on, logic [47:0] base, logic [4:0] sh, logic [4:0] ns,
                            logic [31:0] seed);
      csr_write(CSR_ENABLED, {47'd0, on});
      csr_write(CSR_POOL_BASE, base);
      csr_write(CSR_PAGE_SHIFT, {43'd0, sh});
      csr_write(CSR_SLOTS, {43'd0, ns});
      csr_write(CSR_RNG_SEED, {16'd0, seed});
      csr_wr_en <= 0;
      cur_shift = (sh < MIN_SHIFT) ? MIN_SHIFT : (sh > MAX_SHIFT) ? MAX_SHIFT : sh;
      cur_slots = (ns < 1) ? 1 : (ns > 16) ? 16 : ns;
      cur_base = base;
      live_addr.delete();
      gone_addr.delete();
      @(negedge clock);
   endtask

   task automatic random_item();
      int r;
      int k;
      logic [16:0] sz, al;
      logic [47:0] fa;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         k = $urandom_range(0, cur_shift);
         al = 17'd1 << k;
         sz = 17'($urandom_range(0, (1 << cur_shift) - 1));
         case ($urandom_range(0, 9))
            0: al = 17'($urandom);
            1: sz = 17'($urandom);
            2: sz = 0;
            3: al = 0;
            default: ;
         endcase
         send(1'(CMD_ALLOC), sz, al, 48'($urandom));
      end else begin
         if (r < 80 && live_addr.size() > 0) begin
            k = $urandom_range(0, live_addr.size() - 1);
            fa = live_addr[k];
            live_addr.delete(k);
            gone_addr.push_back(fa);
         end else if (r < 88 && gone_addr.size() > 0) begin
            fa = gone_addr[$urandom_range(0, gone_addr.size() - 1)];
         end else if (r < 95) begin
            fa = cur_base + 48'($urandom_range(0, (2 * cur_slots + 2) << cur_shift));
         end else begin
            fa = 48'({$urandom, $urandom});
         end
         send(1'(CMD_FREE), 17'($urandom), 17'($urandom), fa);
      end
      req_gap();
   endtask

   initial begin
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      csr_wr_en = 0;
      csr_index = CSR_ENABLED;
      csr_wdata = '0;
      no_idle = 0;
      cur_shift = MIN_SHIFT;
      cur_slots = 16;
      cur_base = '0;
      reset = 1;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // pool still disabled after reset
      send(1'(CMD_ALLOC), 17'd16, 17'd0, '0);
      send(1'(CMD_ALLOC), 17'd0, 17'd0, '0);
      drain();
      configure(1, 48'h0, 5'd12, 5'd2, 32'h1);
      // freeing a never-used slot at address zero matches its cleared owner
      send(1'(CMD_FREE), 17'd0, 17'd0, 48'h0);
      send(1'(CMD_FREE), 17'd0, 17'd0, 48'h0);
      send(1'(CMD_ALLOC), 17'd0, 17'd0, '0);
      send(1'(CMD_ALLOC), 17'd65536, 17'd16, '0);
      send(1'(CMD_ALLOC), 17'd16, 17'd3, '0);
      send(1'(CMD_ALLOC), 17'd16, 17'd8192, '0);
      send(1'(CMD_ALLOC), 17'd4096, 17'd4096, '0);
      send(1'(CMD_ALLOC), 17'h1FFFF, 17'h1FFFF, '0);
      send(1'(CMD_ALLOC), 17'd1, 17'd1, '0);
      send(1'(CMD_ALLOC), 17'd1, 17'd1, '0);
      send(1'(CMD_FREE), 17'h1FFFF, 17'h1FFFF, 48'hFFFF_FFFF_FFFF);
      send(1'(CMD_FREE), 17'd0, 17'd0, 48'h0000_0000_2800);
      send(1'(CMD_FREE), 17'd0, 17'd0, 48'h0000_0000_3000);
      drain();
      configure(1, 48'hFFFF_FFFF_0000, 5'd16, 5'd16, 32'hFFFF_FFFF);
      send(1'(CMD_ALLOC), 17'd65536, 17'd65536, '0);
      send(1'(CMD_ALLOC), 17'd1, 17'd0, '0);
      send(1'(CMD_FREE), 17'd0, 17'd0, 48'h0);
      drain();

      for (int p = 0; p < 9; p++) begin
         no_idle = (p == 4);
         case (p)
            0: configure(1, 48'h0, 5'd12, 5'd16, $urandom);
            1: configure(1, 48'hFFFF_FFFF_0000, 5'd16, 5'd1, 32'hFFFF_FFFF);
            2: configure(1, {$urandom, 16'd0} & 48'hFFFF_FFFF_F000, 5'd0, 5'd0, 32'd0);
            3: configure(1, {$urandom, 16'd0}, 5'd31, 5'd31, $urandom);
            4: configure(1, {$urandom, 16'd0}, 5'd14, 5'd4, $urandom);
            5: configure(0, {$urandom, 16'd0}, 5'd13, 5'd8, $urandom);
            default: configure(1, {$urandom, 16'd0}, 5'($urandom_range(12, 16)),
                               5'($urandom_range(1, 16)), $urandom | 1);
         endcase
         repeat ((p == 5) ? 40 : 175) random_item();
         drain();
      end

      if (errors == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
